[sv/quaternion_from_matrix_unit_defines.svh]
// Assertion macros used by the checker file
`ifndef QUATERNION_FROM_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_FROM_MATRIX_UNIT_DEFINES_SVH

// Check that is quiet while reset is high
`define QFM_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("qfm check failed");

// Check that also runs through reset
`define QFM_CHECK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("qfm reset check failed");

`endif

[sv/qfm_pkg.sv]
package qfm_pkg;

   // Default fraction bits and width of matrix elements and quaternion parts
   localparam int FRAC_BITS_DEF = 14;
   localparam int ELEM_W        = 16;

   // Saturation bounds
   localparam int Q_MAX     = 32767;
   localparam int Q_NEG_MAG = 32768;

   // Component solved first
   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;
   localparam logic [1:0] SEL_W = 2'd3;

   typedef struct packed {
      logic signed [ELEM_W-1:0] row0_col0;
      logic signed [ELEM_W-1:0] row0_col1;
      logic signed [ELEM_W-1:0] row0_col2;
      logic signed [ELEM_W-1:0] row1_col0;
      logic signed [ELEM_W-1:0] row1_col1;
      logic signed [ELEM_W-1:0] row1_col2;
      logic signed [ELEM_W-1:0] row2_col0;
      logic signed [ELEM_W-1:0] row2_col1;
      logic signed [ELEM_W-1:0] row2_col2;
   } req_payload_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] quat_x;
      logic signed [ELEM_W-1:0] quat_y;
      logic signed [ELEM_W-1:0] quat_z;
      logic signed [ELEM_W-1:0] quat_w;
      logic                     bad_input;
   } rsp_payload_type;

endpackage

[sv/qfm_chan_if.sv]
// Matrix request channel
interface qfm_req_if;
   logic                     valid;
   logic                     ready;
   qfm_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// Quaternion response channel
interface qfm_rsp_if;
   logic                     valid;
   logic                     ready;
   qfm_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/qfm_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage:
// root = floor(sqrt(rad << SHIFT))
module qfm_sqrt_pipe #(
   parameter int RAD_W = 18,
   parameter int SHIFT = 14
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [RAD_W-1:0]           rad,
   output logic [(RAD_W+SHIFT+1)/2-1:0] root
);
   localparam int VW = RAD_W + SHIFT;
   localparam int SQ = (VW + 1) / 2;

   logic [SQ+1:0]   rem_ff  [SQ];
   logic [SQ-1:0]   root_ff [SQ];
   logic [2*SQ-1:0] v_ff    [SQ];

   genvar k;
   generate
      for (k = 0; k < SQ; k++) begin : g_stage
         logic [SQ+1:0]   rem_i;
         logic [SQ-1:0]   root_i;
         logic [2*SQ-1:0] v_i;
         logic [SQ+1:0]   t_c;
         logic [SQ+1:0]   trial_c;
         logic            ge_c;

         if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign v_i    = (2*SQ)'({rad, {SHIFT{1'b0}}});
         end else begin : g_next
            assign rem_i  = rem_ff[k-1];
            assign root_i = root_ff[k-1];
            assign v_i    = v_ff[k-1];
         end

         // bring down two radicand bits, try root*4+1
         assign t_c     = {rem_i[SQ-1:0], v_i[2*SQ-1 -: 2]};
         assign trial_c = {root_i, 2'b01};
         assign ge_c    = (t_c >= trial_c);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= ge_c ? (t_c - trial_c) : t_c;
               root_ff[k] <= {root_i[SQ-2:0], ge_c};
               v_ff[k]    <= {v_i[2*SQ-3:0], 2'b00};
            end
         end
      end
   endgenerate

   assign root = root_ff[SQ-1];

endmodule

[sv/qfm_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage: quo = num / den
module qfm_div_pipe #(
   parameter int N_W = 31,
   parameter int D_W = 17
) (
   input  logic           clock,
   input  logic           en,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [N_W-1:0] quo
);
   logic [D_W-1:0] rem_ff [N_W];
   logic [N_W-1:0] num_ff [N_W];
   logic [N_W-1:0] quo_ff [N_W];
   logic [D_W-1:0] den_ff [N_W];

   genvar k;
   generate
      for (k = 0; k < N_W; k++) begin : g_stage
         logic [D_W-1:0] rem_i;
         logic [N_W-1:0] num_i;
         logic [N_W-1:0] quo_i;
         logic [D_W-1:0] den_i;
         logic [D_W:0]   t_c;
         logic [D_W:0]   diff_c;
         logic           ge_c;

         if (k == 0) begin : g_first
            assign rem_i = '0;
            assign num_i = num;
            assign quo_i = '0;
            assign den_i = den;
         end else begin : g_next
            assign rem_i = rem_ff[k-1];
            assign num_i = num_ff[k-1];
            assign quo_i = quo_ff[k-1];
            assign den_i = den_ff[k-1];
         end

         // shift in next numerator bit, subtract divisor if it fits
         assign t_c    = {rem_i, num_i[N_W-1]};
         assign diff_c = t_c - {1'b0, den_i};
         assign ge_c   = (t_c >= {1'b0, den_i});

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge_c ? diff_c[D_W-1:0] : t_c[D_W-1:0];
               num_ff[k] <= {num_i[N_W-2:0], 1'b0};
               quo_ff[k] <= {quo_i[N_W-2:0], ge_c};
               den_ff[k] <= den_i;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[N_W-1];

endmodule

[sv/quaternion_from_matrix_unit.sv]
// Channel | Dir | Payload
// req_    | in  | 3x3 matrix, nine signed Q1.FRAC_BITS elements
// rsp_    | out | quaternion x, y, z, w (saturated) and bad_input flag
//
// One matrix per cycle while the output is not stalled. The pipeline has an input register,
// SQ = (max(FRAC_BITS+2, 19) - 1 + FRAC_BITS + 1) / 2 root stages,
// ND = 17 + FRAC_BITS divider stages and an output register.
// The whole pipeline advances together; it holds when a response waits unread.
// Synchronous reset clears the valid bits only.
module quaternion_from_matrix_unit #(
   parameter int FRAC_BITS = qfm_pkg::FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   qfm_req_if.sink     req_chan,
   qfm_rsp_if.source   rsp_chan
);
   localparam int E_W  = qfm_pkg::ELEM_W;
   localparam int RS_W = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
   localparam int SQ   = (RS_W - 1 + FRAC_BITS + 1) / 2;
   localparam int ND   = 17 + FRAC_BITS;
   localparam int D_W  = SQ + 1;

   typedef struct packed {
      logic [1:0]        sel;
      logic              bad;
      logic [2:0][16:0]  mag;
      logic [2:0]        neg;
   } line_a_type;

   typedef struct packed {
      logic [1:0]    sel;
      logic          bad;
      logic [2:0]    neg;
      logic [SQ-1:0] root;
   } line_b_type;

   logic en;

   // global advance: stall only when the response is held
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- prep: case select, radicand, numerators ----------
   logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [17:0] tr_c, rs_c;
   logic signed [17:0] dx_c, dy_c, dz_c, s01_c, s02_c, s12_c;
   logic signed [17:0] l0_c, l1_c, l2_c;
   logic        [1:0]  sel_c;
   logic signed [RS_W-1:0] r_c;
   logic               bad_c;

   assign e00 = 18'(req_chan.data.row0_col0);
   assign e01 = 18'(req_chan.data.row0_col1);
   assign e02 = 18'(req_chan.data.row0_col2);
   assign e10 = 18'(req_chan.data.row1_col0);
   assign e11 = 18'(req_chan.data.row1_col1);
   assign e12 = 18'(req_chan.data.row1_col2);
   assign e20 = 18'(req_chan.data.row2_col0);
   assign e21 = 18'(req_chan.data.row2_col1);
   assign e22 = 18'(req_chan.data.row2_col2);

   assign tr_c  = e00 + e11 + e22;
   assign dx_c  = e12 - e21;
   assign dy_c  = e20 - e02;
   assign dz_c  = e01 - e10;
   assign s01_c = e01 + e10;
   assign s02_c = e02 + e20;
   assign s12_c = e21 + e12;

   always_comb begin
      if (!tr_c[17]) begin
         sel_c = qfm_pkg::SEL_W;
         rs_c  = tr_c;
      end else if (e00 > e11 && e00 > e22) begin
         sel_c = qfm_pkg::SEL_X;
         rs_c  = e00 - e11 - e22;
      end else if (e11 > e22) begin
         sel_c = qfm_pkg::SEL_Y;
         rs_c  = e11 - e00 - e22;
      end else begin
         sel_c = qfm_pkg::SEL_Z;
         rs_c  = e22 - e00 - e11;
      end
   end

   // lanes hold the other three parts in x, y, z, w order
   always_comb begin
      unique case (sel_c)
         qfm_pkg::SEL_W: begin
            l0_c = dx_c;  l1_c = dy_c;  l2_c = dz_c;
         end
         qfm_pkg::SEL_X: begin
            l0_c = s01_c; l1_c = s02_c; l2_c = dx_c;
         end
         qfm_pkg::SEL_Y: begin
            l0_c = s01_c; l1_c = s12_c; l2_c = dy_c;
         end
         default: begin
            l0_c = s02_c; l1_c = s12_c; l2_c = dz_c;
         end
      endcase
   end

   assign r_c   = {{(RS_W-18){rs_c[17]}}, rs_c} + (RS_W'(1) << FRAC_BITS);
   assign bad_c = r_c[RS_W-1] || (r_c == '0);

   function automatic logic [16:0] abs18(input logic signed [17:0] d);
      logic [17:0] m;
      m = d[17] ? 18'(-d) : 18'(d);
      return m[16:0];
   endfunction

   logic                s0_vld_ff;
   line_a_type          s0_ff;
   logic [RS_W-2:0]     s0_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff.sel    <= sel_c;
         s0_ff.bad    <= bad_c;
         s0_ff.mag[0] <= abs18(l0_c);
         s0_ff.mag[1] <= abs18(l1_c);
         s0_ff.mag[2] <= abs18(l2_c);
         s0_ff.neg    <= {l2_c[17], l1_c[17], l0_c[17]};
         s0_rad_ff    <= r_c[RS_W-2:0];
      end
   end

   // ---------------- square root stages -------------------------------
   logic [SQ-1:0] root_w;

   qfm_sqrt_pipe #(
      .RAD_W (RS_W - 1),
      .SHIFT (FRAC_BITS)
   ) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (s0_rad_ff),
      .root  (root_w)
   );

   logic [SQ-1:0]  va_ff;
   line_a_type     a_ff [SQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
      end else if (en) begin
         va_ff <= {va_ff[SQ-2:0], s0_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= s0_ff;
         for (int k = 1; k < SQ; k++) begin
            a_ff[k] <= a_ff[k-1];
         end
      end
   end

   // ---------------- divider stages: d * ONE / (2 s) -----------------
   logic [ND-1:0] quo_w [3];
   logic [D_W-1:0] den_w;

   assign den_w = {root_w, 1'b0};

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         qfm_div_pipe #(
            .N_W (ND),
            .D_W (D_W)
         ) u_div (
            .clock (clock),
            .en    (en),
            .num   ({a_ff[SQ-1].mag[g], {FRAC_BITS{1'b0}}}),
            .den   (den_w),
            .quo   (quo_w[g])
         );
      end
   endgenerate

   logic [ND-1:0]  vb_ff;
   line_b_type     b_ff [ND];

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
      end else if (en) begin
         vb_ff <= {vb_ff[ND-2:0], va_ff[SQ-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff[0].sel  <= a_ff[SQ-1].sel;
         b_ff[0].bad  <= a_ff[SQ-1].bad;
         b_ff[0].neg  <= a_ff[SQ-1].neg;
         b_ff[0].root <= root_w;
         for (int k = 1; k < ND; k++) begin
            b_ff[k] <= b_ff[k-1];
         end
      end
   end

   // ---------------- sign, saturate, place components ----------------
   function automatic logic [E_W-1:0] sat_q(input logic [ND-1:0] mag, input logic neg);
      logic [ND-1:0] n;
      n = ND'(0) - mag;
      if (neg) begin
         return (mag > ND'(qfm_pkg::Q_NEG_MAG)) ? {1'b1, {(E_W-1){1'b0}}} : n[E_W-1:0];
      end
      return (mag > ND'(qfm_pkg::Q_MAX)) ? {1'b0, {(E_W-1){1'b1}}} : mag[E_W-1:0];
   endfunction

   line_b_type    bl;
   logic [E_W-1:0] h_c, q0_c, q1_c, q2_c;
   qfm_pkg::rsp_payload_type rsp_c;

   assign bl   = b_ff[ND-1];
   assign h_c  = sat_q(ND'(bl.root) >> 1, 1'b0);
   assign q0_c = sat_q(quo_w[0], bl.neg[0]);
   assign q1_c = sat_q(quo_w[1], bl.neg[1]);
   assign q2_c = sat_q(quo_w[2], bl.neg[2]);

   always_comb begin
      rsp_c.bad_input = bl.bad;
      unique case (bl.sel)
         qfm_pkg::SEL_W: begin
            rsp_c.quat_x = q0_c; rsp_c.quat_y = q1_c;
            rsp_c.quat_z = q2_c; rsp_c.quat_w = h_c;
         end
         qfm_pkg::SEL_X: begin
            rsp_c.quat_x = h_c;  rsp_c.quat_y = q0_c;
            rsp_c.quat_z = q1_c; rsp_c.quat_w = q2_c;
         end
         qfm_pkg::SEL_Y: begin
            rsp_c.quat_x = q0_c; rsp_c.quat_y = h_c;
            rsp_c.quat_z = q1_c; rsp_c.quat_w = q2_c;
         end
         default: begin
            rsp_c.quat_x = q0_c; rsp_c.quat_y = q1_c;
            rsp_c.quat_z = h_c;  rsp_c.quat_w = q2_c;
         end
      endcase
      if (bl.bad) begin
         rsp_c.quat_x = '0;
         rsp_c.quat_y = '0;
         rsp_c.quat_z = '0;
         rsp_c.quat_w = '0;
      end
   end

   // ---------------- output register ----------------------------------
   logic                     rsp_vld_ff;
   qfm_pkg::rsp_payload_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vb_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_c;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_ff;

endmodule

[sv/qfm_checker.sv]
`include "quaternion_from_matrix_unit_defines.svh"

// Port-level checks on the quaternion unit
module qfm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input qfm_pkg::rsp_payload_type rsp_data
);

   // sign bits of the four parts
   logic [3:0] sign_c;

   assign sign_c = {rsp_data.quat_x[15], rsp_data.quat_y[15],
                    rsp_data.quat_z[15], rsp_data.quat_w[15]};

   // a held response keeps its contents
   `QFM_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // a rejected matrix gives a zero w part (w, bits 16:1, sits just above the flag)
   `QFM_CHECK(a_bad_zero, rsp_valid && rsp_data.bad_input |-> rsp_data[16:1] == '0)

   // the solved part is never negative, so the four parts are never all negative
   `QFM_CHECK(a_solved_pos, rsp_valid && !rsp_data.bad_input |-> !(&sign_c))

   // no new transfer is taken while a response is stalled
   `QFM_CHECK(a_stall_block, rsp_valid && !rsp_ready |-> !req_ready)

   // response valid drops after reset
   `QFM_CHECK_RST(a_rst_clear, reset |=> !rsp_valid)

endmodule

bind quaternion_from_matrix_unit qfm_checker u_qfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
